// ----- rtl/tkpq_pkg.sv -----
// ----------------------------------------------------------------------------
// tkpq_pkg: shared types and codes for the two-key priority queue
// Entry layout, operation and status codes, cell command and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tkpq_pkg;

  localparam int TAG_W = 16;
  localparam int SEV_W = 8;
  localparam int DUR_W = 16;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_REMOVE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [SEV_W-1:0] severity;
    logic [DUR_W-1:0] duration;
  } entry_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

  typedef enum logic {
    PQ_IDLE,
    PQ_SETTLE
  } pq_state_t;

endpackage : tkpq_pkg

`default_nettype wire

// ----- rtl/tkpq_cell.sv -----
// ----------------------------------------------------------------------------
// tkpq_cell: one slot of the sorted chain
// Holds one entry, compares it with the incoming entry and shifts toward the
// tail on insert or toward the head on remove.
// ----------------------------------------------------------------------------
`default_nettype none

module tkpq_cell
  import tkpq_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  input  wire cell_cmd_t  cmd,
  input  wire entry_t     new_entry,
  input  wire             prev_valid,
  input  wire entry_t     prev_entry,
  input  wire             prev_beats,
  input  wire             next_valid,
  input  wire entry_t     next_entry,
  output logic            valid,
  output entry_t          entry,
  output logic            beats
);

  logic   valid_r;
  logic   valid_nxt;
  entry_t entry_r;
  entry_t entry_nxt;

  // new entry goes ahead of this slot; equal keys keep arrival order
  always_comb begin
    beats = !valid_r ||
            (new_entry.severity > entry_r.severity) ||
            ((new_entry.severity == entry_r.severity) &&
             (new_entry.duration < entry_r.duration));
  end

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (cmd.ins) begin
      if (prev_beats) begin
        valid_nxt = prev_valid;
        entry_nxt = prev_entry;
      end else if (beats) begin
        valid_nxt = 1'b1;
        entry_nxt = new_entry;
      end
    end else if (cmd.rem) begin
      valid_nxt = next_valid;
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign valid = valid_r;
  assign entry = entry_r;

endmodule : tkpq_cell

`default_nettype wire

// ----- rtl/two_key_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// two_key_priority_queue_core: bounded priority queue on a sorted cell chain
// Higher severity first, then shorter duration, then earlier arrival.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   in      | input     | in_valid / in_stall  | func, tag, severity, duration
//   out     | output    | out_valid / out_stall| status, removed entry, head, fill
//
// Each transaction has a shift step in which every cell moves in parallel,
// and a settle step that registers the new head.
// Latency is independent of occupancy; a new transaction is accepted only
// after the previous one has settled.
// rst_n (synchronous) empties the chain.
// A result held by out_stall does not block the next transaction; a second
// result waits in the settle cycle until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module two_key_priority_queue_core
  import tkpq_pkg::*;
#(
  parameter int CAPACITY = 64,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire                 in_func,
  input  wire  [TAG_W-1:0]    in_tag_in,
  input  wire  [SEV_W-1:0]    in_severity_in,
  input  wire  [DUR_W-1:0]    in_duration_in,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [TAG_W-1:0]    out_removed_tag,
  output logic [SEV_W-1:0]    out_removed_severity,
  output logic [DUR_W-1:0]    out_removed_duration,
  output logic [TAG_W-1:0]    out_head_tag,
  output logic [SEV_W-1:0]    out_head_severity,
  output logic [DUR_W-1:0]    out_head_duration,
  output logic [CW-1:0]       out_occupancy,
  output logic                out_is_empty,
  output logic                out_is_full
);

  pq_state_t state_r;
  pq_state_t state_nxt;

  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic [STATUS_W-1:0] status_r;
  entry_t              removed_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                out_load;

  logic                in_acc;
  logic                q_full;
  logic                q_empty;
  cell_cmd_t           cmd;
  entry_t              new_entry;

  logic   [CAPACITY-1:0] cell_valid;
  logic   [CAPACITY-1:0] cell_beats;
  entry_t                cell_entry [CAPACITY];

  entry_t              out_removed_r;
  entry_t              out_head_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [CW-1:0]       out_occupancy_r;
  logic                out_is_empty_r;
  logic                out_is_full_r;

  assign new_entry = '{tag: in_tag_in, severity: in_severity_in, duration: in_duration_in};
  assign q_full    = (count_r == CW'(CAPACITY));
  assign q_empty   = (count_r == '0);
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    cmd.ins = in_acc && (in_func == FN_INSERT) && !q_full;
    cmd.rem = in_acc && (in_func == FN_REMOVE) && !q_empty;
  end

  // the chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   p_valid;
    logic   p_beats;
    entry_t p_entry;
    logic   n_valid;
    entry_t n_entry;

    if (i == 0) begin : g_head
      assign p_valid = 1'b0;
      assign p_beats = 1'b0;
      assign p_entry = '0;
    end else begin : g_mid
      assign p_valid = cell_valid[i-1];
      assign p_beats = cell_beats[i-1];
      assign p_entry = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_entry = '0;
    end else begin : g_body
      assign n_valid = cell_valid[i+1];
      assign n_entry = cell_entry[i+1];
    end

    tkpq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .new_entry  (new_entry),
      .prev_valid (p_valid),
      .prev_entry (p_entry),
      .prev_beats (p_beats),
      .next_valid (n_valid),
      .next_entry (n_entry),
      .valid      (cell_valid[i]),
      .entry      (cell_entry[i]),
      .beats      (cell_beats[i])
    );
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;
    count_nxt     = count_r;
    case (state_r)
      PQ_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = PQ_SETTLE;
        end
      end
      PQ_SETTLE: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = PQ_IDLE;
        end
      end
      default: begin
        state_nxt = PQ_IDLE;
      end
    endcase
    if (cmd.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PQ_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // per-transaction results captured at the shift edge
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if ((in_func == FN_INSERT) && q_full) begin
        status_r <= ST_FULL;
      end else if ((in_func == FN_REMOVE) && q_empty) begin
        status_r <= ST_EMPTY;
      end else begin
        status_r <= ST_DONE;
      end
      removed_r <= cmd.rem ? cell_entry[0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r    <= status_r;
      out_removed_r   <= removed_r;
      out_head_r      <= cell_valid[0] ? cell_entry[0] : '0;
      out_occupancy_r <= count_r;
      out_is_empty_r  <= q_empty;
      out_is_full_r   <= q_full;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_removed_tag      = out_removed_r.tag;
  assign out_removed_severity = out_removed_r.severity;
  assign out_removed_duration = out_removed_r.duration;
  assign out_head_tag         = out_head_r.tag;
  assign out_head_severity    = out_head_r.severity;
  assign out_head_duration    = out_head_r.duration;
  assign out_occupancy        = out_occupancy_r;
  assign out_is_empty         = out_is_empty_r;
  assign out_is_full          = out_is_full_r;

`ifndef SYNTHESIS
  // head cell occupied exactly when the count is nonzero
  a_head_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
    cell_valid[0] == (count_r != '0))
    else $error("head cell valid disagrees with count");

  // tail cell occupied exactly when full
  a_tail_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
    cell_valid[CAPACITY-1] == q_full)
    else $error("tail cell valid disagrees with full");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the chain");

  // every accepted transaction gets a settle cycle before the next one
  a_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == PQ_SETTLE) && !in_acc)
    else $error("transaction accepted during settle");
`endif

endmodule : two_key_priority_queue_core

`default_nettype wire

// ----- bench/two_key_priority_queue_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_key_priority_queue_core_tb: self-checking bench for the priority queue
// A queue-fed driver sends inserts and removes with random gaps. A monitor
// holds a shadow sorted chain that predicts every reply and checks it field
// by field, under random back-pressure on the result side.
// ----------------------------------------------------------------------------

module two_key_priority_queue_core_tb;
  import tkpq_pkg::*;

  localparam int CAPACITY = 64;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RANDOM_ITEMS = 1350;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT = 27;

  typedef struct {
    logic             func;
    entry_t           ent;
    bit               drain_first;
  } queue_op_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    entry_t              removed;
    entry_t              head;
    logic [CW-1:0]       occupancy;
    logic                is_empty;
    logic                is_full;
  } queue_reply_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_func = FN_INSERT;
  logic [TAG_W-1:0]    in_tag_in = '0;
  logic [SEV_W-1:0]    in_severity_in = '0;
  logic [DUR_W-1:0]    in_duration_in = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [TAG_W-1:0]    out_removed_tag;
  logic [SEV_W-1:0]    out_removed_severity;
  logic [DUR_W-1:0]    out_removed_duration;
  logic [TAG_W-1:0]    out_head_tag;
  logic [SEV_W-1:0]    out_head_severity;
  logic [DUR_W-1:0]    out_head_duration;
  logic [CW-1:0]       out_occupancy;
  logic                out_is_empty;
  logic                out_is_full;

  two_key_priority_queue_core #(.CAPACITY(CAPACITY)) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_func              (in_func),
    .in_tag_in            (in_tag_in),
    .in_severity_in       (in_severity_in),
    .in_duration_in       (in_duration_in),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_removed_tag      (out_removed_tag),
    .out_removed_severity (out_removed_severity),
    .out_removed_duration (out_removed_duration),
    .out_head_tag         (out_head_tag),
    .out_head_severity    (out_head_severity),
    .out_head_duration    (out_head_duration),
    .out_occupancy        (out_occupancy),
    .out_is_empty         (out_is_empty),
    .out_is_full          (out_is_full)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  queue_op_t    op_backlog[$];
  queue_reply_t replies_due[$];

  // shadow chain, kept sorted from head to tail
  entry_t chain_entries[CAPACITY];
  int     chain_rank[CAPACITY];
  int     chain_count = 0;

  int  gen_fill = 0;
  int  n_queued = 0;
  int  n_errors = 0;
  int  n_accepted = 0;
  int  n_inserts = 0;
  int  n_removes = 0;
  int  n_refused_full = 0;
  int  n_refused_empty = 0;
  int  n_hit_full = 0;
  int  n_hit_empty = 0;
  int  cycles = 0;
  bit  in_accepted = 1'b0;

  // no idling on either side for a long stretch in the middle
  wire calm = (n_accepted >= 450) && (n_accepted < 750);

  function automatic bit outranks(input logic [SEV_W-1:0] sa, input logic [DUR_W-1:0] da,
                                  input int ra, input logic [SEV_W-1:0] sb,
                                  input logic [DUR_W-1:0] db, input int rb);
    if (sa != sb) return sa > sb;
    if (da != db) return da < db;
    return ra < rb;
  endfunction

  function automatic queue_reply_t serve_op(input logic func, input entry_t ent);
    queue_reply_t r;
    int pos;
    int rank;
    int gone;
    r.status = ST_DONE;
    r.removed = '0;
    r.head = '0;
    if (func == FN_INSERT) begin
      if (chain_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        rank = chain_count;
        pos = 0;
        while (pos < chain_count &&
               !outranks(ent.severity, ent.duration, rank, chain_entries[pos].severity,
                         chain_entries[pos].duration, chain_rank[pos]))
          pos++;
        for (int i = chain_count; i > pos; i--) begin
          chain_entries[i] = chain_entries[i-1];
          chain_rank[i] = chain_rank[i-1];
        end
        chain_entries[pos] = ent;
        chain_rank[pos] = rank;
        chain_count++;
      end
    end else begin
      if (chain_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        gone = chain_rank[0];
        r.removed = chain_entries[0];
        for (int i = 0; i + 1 < chain_count; i++) begin
          chain_entries[i] = chain_entries[i+1];
          chain_rank[i] = chain_rank[i+1];
        end
        chain_count--;
        // later arrivals move up one rank
        for (int i = 0; i < chain_count; i++)
          if (chain_rank[i] > gone) chain_rank[i]--;
      end
    end
    if (chain_count > 0) r.head = chain_entries[0];
    r.occupancy = chain_count[CW-1:0];
    r.is_empty = (chain_count == 0);
    r.is_full = (chain_count == CAPACITY);
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    n_errors++;
  endtask

  task automatic add_op(input logic func, input logic [TAG_W-1:0] tag,
                        input logic [SEV_W-1:0] sev, input logic [DUR_W-1:0] dur);
    queue_op_t op;
    op.func = func;
    op.ent.tag = tag;
    op.ent.severity = sev;
    op.ent.duration = dur;
    op.drain_first = (n_queued == 600) || (n_queued == 1100);
    op_backlog.push_back(op);
    n_queued++;
    if (func == FN_INSERT && gen_fill < CAPACITY) gen_fill++;
    if (func == FN_REMOVE && gen_fill > 0) gen_fill--;
  endtask

  function automatic logic [SEV_W-1:0] pick_severity();
    case ($urandom_range(0, 3))
      0: return SEV_W'($urandom_range(0, 3));
      1: return $urandom_range(0, 1) ? {SEV_W{1'b1}} : '0;
      default: return SEV_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 3))
      0: return DUR_W'($urandom_range(0, 3));
      1: return $urandom_range(0, 1) ? {DUR_W{1'b1}} : '0;
      default: return DUR_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic add_random_op(input bit do_insert);
    add_op(do_insert ? FN_INSERT : FN_REMOVE, TAG_W'($urandom_range(0, 65535)),
           pick_severity(), pick_duration());
  endtask

  // driver: payload changes only at the falling edge, held while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      if (!in_valid || in_accepted) begin
        in_accepted = 1'b0;
        if (op_backlog.size() > 0 &&
            !(op_backlog[0].drain_first && replies_due.size() > 0) &&
            (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_func <= op_backlog[0].func;
          in_tag_in <= op_backlog[0].ent.tag;
          in_severity_in <= op_backlog[0].ent.severity;
          in_duration_in <= op_backlog[0].ent.duration;
          void'(op_backlog.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks replies, then predicts for the transaction taken this edge
  always @(posedge clk) begin
    queue_reply_t want;
    entry_t ent;
    cycles++;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          flag_mismatch("unexpected result", {30'd0, out_status}, 32'd0);
        end else begin
          want = replies_due.pop_front();
          if (out_status !== want.status)
            flag_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_removed_tag !== want.removed.tag)
            flag_mismatch("removed_tag", 32'(out_removed_tag), 32'(want.removed.tag));
          if (out_removed_severity !== want.removed.severity)
            flag_mismatch("removed_severity", 32'(out_removed_severity),
                          32'(want.removed.severity));
          if (out_removed_duration !== want.removed.duration)
            flag_mismatch("removed_duration", 32'(out_removed_duration),
                          32'(want.removed.duration));
          if (out_head_tag !== want.head.tag)
            flag_mismatch("head_tag", 32'(out_head_tag), 32'(want.head.tag));
          if (out_head_severity !== want.head.severity)
            flag_mismatch("head_severity", 32'(out_head_severity), 32'(want.head.severity));
          if (out_head_duration !== want.head.duration)
            flag_mismatch("head_duration", 32'(out_head_duration), 32'(want.head.duration));
          if (out_occupancy !== want.occupancy)
            flag_mismatch("occupancy", 32'(out_occupancy), 32'(want.occupancy));
          if (out_is_empty !== want.is_empty)
            flag_mismatch("is_empty", 32'(out_is_empty), 32'(want.is_empty));
          if (out_is_full !== want.is_full)
            flag_mismatch("is_full", 32'(out_is_full), 32'(want.is_full));
        end
      end
      if (in_valid && !in_stall) begin
        in_accepted = 1'b1;
        n_accepted++;
        ent.tag = in_tag_in;
        ent.severity = in_severity_in;
        ent.duration = in_duration_in;
        want = serve_op(in_func, ent);
        replies_due.push_back(want);
        if (want.status == ST_FULL) n_refused_full++;
        else if (want.status == ST_EMPTY) n_refused_empty++;
        else if (in_func == FN_INSERT) n_inserts++;
        else n_removes++;
        if (want.status == ST_DONE && want.is_full) n_hit_full++;
        if (want.status == ST_DONE && want.is_empty && in_func == FN_REMOVE) n_hit_empty++;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int mode;
    int stop_at;
    // directed: empty remove, key extremes, ties, rank drop after a removal
    add_op(FN_REMOVE, 16'hffff, 8'hff, 16'hffff);
    add_op(FN_INSERT, 16'h0000, 8'h00, 16'h0000);
    add_op(FN_INSERT, 16'hffff, 8'hff, 16'hffff);
    add_op(FN_INSERT, 16'h1234, 8'hff, 16'h0000);
    add_op(FN_INSERT, 16'h4321, 8'hff, 16'h0000);
    add_op(FN_INSERT, 16'h0abc, 8'hff, 16'h0001);
    repeat (5) add_op(FN_REMOVE, 16'h5a5a, 8'ha5, 16'h5a5a);
    add_op(FN_REMOVE, 16'h0000, 8'h00, 16'h0000);
    add_op(FN_INSERT, 16'h00a1, 8'h05, 16'h0005);
    add_op(FN_INSERT, 16'h00b2, 8'h09, 16'h0009);
    add_op(FN_INSERT, 16'h00c3, 8'h05, 16'h0005);
    add_op(FN_REMOVE, 16'h0000, 8'h00, 16'h0000);
    add_op(FN_INSERT, 16'h00d4, 8'h05, 16'h0005);
    repeat (3) add_op(FN_REMOVE, 16'h0000, 8'h00, 16'h0000);

    // random: fill past the top, drain past the bottom, and mixed stretches
    stop_at = n_queued + RANDOM_ITEMS;
    while (n_queued < stop_at) begin
      mode = $urandom_range(0, 3);
      case (mode)
        0: begin
          while (gen_fill < CAPACITY) add_random_op($urandom_range(0, 99) < 85);
          repeat ($urandom_range(1, 4)) add_random_op(1'b1);
        end
        1: begin
          while (gen_fill > 0) add_random_op($urandom_range(0, 99) < 15);
          repeat ($urandom_range(1, 4)) add_random_op(1'b0);
        end
        default: begin
          repeat ($urandom_range(10, 60)) add_random_op(1'($urandom_range(0, 1)));
        end
      endcase
    end

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    while (op_backlog.size() > 0 || in_valid || replies_due.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("%0d transactions: %0d inserts, %0d removals, %0d refused full, %0d refused empty",
             n_accepted, n_inserts, n_removes, n_refused_full, n_refused_empty);
    $display("queue filled to capacity %0d times and drained to empty %0d times",
             n_hit_full, n_hit_empty);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule : two_key_priority_queue_core_tb
